[hw/rtl/anchor_box_proposal_decoder_defines.svh]
// ----------------------------------------------------------------------------
// anchor box proposal decoder assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ANCHOR_BOX_PROPOSAL_DECODER_DEFINES_SVH
`define ANCHOR_BOX_PROPOSAL_DECODER_DEFINES_SVH

// same-cycle implication
`define ABPD_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("abpd assertion failed");

// next-cycle implication
`define ABPD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("abpd assertion failed");

`endif

[hw/rtl/abpd_pkg.sv]
// ----------------------------------------------------------------------------
// abpd_pkg
// shared types and constants of the anchor box proposal decoder
// ----------------------------------------------------------------------------
package abpd_pkg;

    localparam int MAX_GRID_DIM_DEF  = 256;
    localparam int MAX_ANCHORS_DEF   = 4;
    localparam int NUM_KEYPOINTS_DEF = 5;

    // compare widths that cover the full parameter ranges
    localparam int DIM_CMP_W = 11;
    localparam int ANC_CMP_W = 5;
    // center of the largest grid times the largest stride
    localparam int CENTER_W  = 17;

    localparam int Q_DEPTH = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCORE_THRESHOLD   = 3'd0,
        REG_GRID_WIDTH        = 3'd1,
        REG_GRID_HEIGHT       = 3'd2,
        REG_STRIDE            = 3'd3,
        REG_ANCHORS_PER_CELL  = 3'd4,
        REG_KEYPOINTS_ENABLED = 3'd5
    } reg_index_t;

    localparam logic CMD_BOX      = 1'b0;
    localparam logic CMD_KEYPOINT = 1'b1;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [8:0]  grid_width;
        logic [8:0]  grid_height;
        logic [6:0]  stride;
        logic [2:0]  anchors_per_cell;
        logic        keypoints_enabled;
    } cfg_t;

    // one classified item on its way to the back end
    typedef struct packed {
        logic               is_keypoint;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic signed [15:0] delta_a;
        logic signed [15:0] delta_b;
        logic signed [15:0] delta_c;
        logic signed [15:0] delta_d;
        logic [15:0]        score;
        logic               last;
    } entry_t;

endpackage

[hw/rtl/anchor_box_proposal_decoder.sv]
// ----------------------------------------------------------------------------
// anchor_box_proposal_decoder
// distance-based box and keypoint decoder over one feature map level
//
//   channel   handshake               payload
//   input     in_valid / in_ready     cmd, score, delta_a .. delta_d
//   result    out_valid / out_ready   is_keypoint, coord_a .. coord_d,
//                                     out_score, last
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one word per cycle while in_ready is high; each result is queued, then registered
// in_ready drops only when the two-entry queue in front of the back end is full
// the back end holds one result in its output register while taking the next
// reset clears the grid walk and the queue and sets the config registers to defaults
// configuration writes are always taken; cfg_ready is high in every cycle
// ----------------------------------------------------------------------------
module anchor_box_proposal_decoder #(
    parameter int MAX_GRID_DIM  = abpd_pkg::MAX_GRID_DIM_DEF,
    parameter int MAX_ANCHORS   = abpd_pkg::MAX_ANCHORS_DEF,
    parameter int NUM_KEYPOINTS = abpd_pkg::NUM_KEYPOINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [abpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [abpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [15:0]                        score,
    input  logic signed [15:0]                 delta_a,
    input  logic signed [15:0]                 delta_b,
    input  logic signed [15:0]                 delta_c,
    input  logic signed [15:0]                 delta_d,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               is_keypoint,
    output logic signed [23:0]                 coord_a,
    output logic signed [23:0]                 coord_b,
    output logic signed [16:0]                 coord_c,
    output logic signed [16:0]                 coord_d,
    output logic [15:0]                        out_score,
    output logic                               last
);
    import abpd_pkg::*;

    cfg_t   cfg_reg;
    logic   fire;
    logic   push, full, pop, q_valid;
    entry_t push_entry, q_entry;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign fire      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_threshold   <= 16'd32768;
            cfg_reg.grid_width        <= 9'd80;
            cfg_reg.grid_height       <= 9'd80;
            cfg_reg.stride            <= 7'd8;
            cfg_reg.anchors_per_cell  <= 3'd2;
            cfg_reg.keypoints_enabled <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCORE_THRESHOLD:   cfg_reg.score_threshold   <= cfg_data;
                REG_GRID_WIDTH:        cfg_reg.grid_width        <= cfg_data[8:0];
                REG_GRID_HEIGHT:       cfg_reg.grid_height       <= cfg_data[8:0];
                REG_STRIDE:            cfg_reg.stride            <= cfg_data[6:0];
                REG_ANCHORS_PER_CELL:  cfg_reg.anchors_per_cell  <= cfg_data[2:0];
                REG_KEYPOINTS_ENABLED: cfg_reg.keypoints_enabled <= cfg_data[0];
                default: ;
            endcase
        end
    end

    abpd_front #(
        .MAX_GRID_DIM  (MAX_GRID_DIM),
        .MAX_ANCHORS   (MAX_ANCHORS),
        .NUM_KEYPOINTS (NUM_KEYPOINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fire       (fire),
        .cmd        (cmd),
        .score      (score),
        .delta_a    (delta_a),
        .delta_b    (delta_b),
        .delta_c    (delta_c),
        .delta_d    (delta_d),
        .push       (push),
        .push_entry (push_entry)
    );

    abpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    abpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_keypoint (is_keypoint),
        .coord_a     (coord_a),
        .coord_b     (coord_b),
        .coord_c     (coord_c),
        .coord_d     (coord_d),
        .out_score   (out_score),
        .last        (last)
    );

endmodule

[hw/rtl/abpd_front.sv]
// ----------------------------------------------------------------------------
// abpd_front
// walks the cell grid, applies the score threshold and keypoint rules
// ----------------------------------------------------------------------------
module abpd_front #(
    parameter int MAX_GRID_DIM  = 256,
    parameter int MAX_ANCHORS   = 4,
    parameter int NUM_KEYPOINTS = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  abpd_pkg::cfg_t        cfg,
    input  logic                  fire,
    input  logic                  cmd,
    input  logic [15:0]           score,
    input  logic signed [15:0]    delta_a,
    input  logic signed [15:0]    delta_b,
    input  logic signed [15:0]    delta_c,
    input  logic signed [15:0]    delta_d,
    output logic                  push,
    output abpd_pkg::entry_t      push_entry
);
    import abpd_pkg::*;

    localparam int CNT_W = (MAX_GRID_DIM > 1) ? $clog2(MAX_GRID_DIM) : 1;
    localparam int AW    = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int KW    = $clog2(NUM_KEYPOINTS + 1);

    logic [CNT_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic [AW-1:0]       anchor_reg, anchor_next;
    logic [CENTER_W-1:0] held_cx_reg, held_cx_next;
    logic [CENTER_W-1:0] held_cy_reg, held_cy_next;
    logic                accepted_reg, accepted_next;
    logic [KW-1:0]       kp_count_reg, kp_count_next;
    logic [15:0]         held_score_reg, held_score_next;

    logic [DIM_CMP_W-1:0] gw, gh, col_p1, row_p1;
    logic [ANC_CMP_W-1:0] na, anchor_p1;
    logic [CENTER_W-1:0]  cx, cy;
    logic                 pass;
    logic                 kp_ok;

    always_comb
    begin
        if (cfg.grid_width == '0)
            gw = DIM_CMP_W'(1);
        else if (DIM_CMP_W'(cfg.grid_width) > DIM_CMP_W'(MAX_GRID_DIM))
            gw = DIM_CMP_W'(MAX_GRID_DIM);
        else
            gw = DIM_CMP_W'(cfg.grid_width);

        if (cfg.grid_height == '0)
            gh = DIM_CMP_W'(1);
        else if (DIM_CMP_W'(cfg.grid_height) > DIM_CMP_W'(MAX_GRID_DIM))
            gh = DIM_CMP_W'(MAX_GRID_DIM);
        else
            gh = DIM_CMP_W'(cfg.grid_height);

        if (cfg.anchors_per_cell == '0)
            na = ANC_CMP_W'(1);
        else if (ANC_CMP_W'(cfg.anchors_per_cell) > ANC_CMP_W'(MAX_ANCHORS))
            na = ANC_CMP_W'(MAX_ANCHORS);
        else
            na = ANC_CMP_W'(cfg.anchors_per_cell);
    end

    assign col_p1    = DIM_CMP_W'(col_reg) + DIM_CMP_W'(1);
    assign row_p1    = DIM_CMP_W'(row_reg) + DIM_CMP_W'(1);
    assign anchor_p1 = ANC_CMP_W'(anchor_reg) + ANC_CMP_W'(1);

    assign cx = CENTER_W'(col_reg) * CENTER_W'(cfg.stride);
    assign cy = CENTER_W'(row_reg) * CENTER_W'(cfg.stride);

    assign pass  = (score >= cfg.score_threshold);
    assign kp_ok = accepted_reg && cfg.keypoints_enabled &&
                   (kp_count_reg < KW'(NUM_KEYPOINTS));

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        anchor_next     = anchor_reg;
        held_cx_next    = held_cx_reg;
        held_cy_next    = held_cy_reg;
        accepted_next   = accepted_reg;
        kp_count_next   = kp_count_reg;
        held_score_next = held_score_reg;
        push            = 1'b0;

        push_entry.is_keypoint = 1'b0;
        push_entry.center_x    = cx;
        push_entry.center_y    = cy;
        push_entry.delta_a     = delta_a;
        push_entry.delta_b     = delta_b;
        push_entry.delta_c     = delta_c;
        push_entry.delta_d     = delta_d;
        push_entry.score       = score;
        push_entry.last        = !cfg.keypoints_enabled;

        if (fire)
        begin
            if (cmd == CMD_BOX)
            begin
                // column fastest, then row, then anchor plane
                if (col_p1 >= gw)
                begin
                    col_next = '0;
                    if (row_p1 >= gh)
                    begin
                        row_next = '0;
                        if (anchor_p1 >= na)
                            anchor_next = '0;
                        else
                            anchor_next = anchor_p1[AW-1:0];
                    end
                    else
                    begin
                        row_next = row_p1[CNT_W-1:0];
                    end
                end
                else
                begin
                    col_next = col_p1[CNT_W-1:0];
                end

                accepted_next = pass;
                if (pass)
                begin
                    kp_count_next   = '0;
                    held_score_next = score;
                    held_cx_next    = cx;
                    held_cy_next    = cy;
                    push            = 1'b1;
                end
            end
            else if (kp_ok)
            begin
                push                   = 1'b1;
                push_entry.is_keypoint = 1'b1;
                push_entry.center_x    = held_cx_reg;
                push_entry.center_y    = held_cy_reg;
                push_entry.score       = held_score_reg;
                push_entry.last        = (kp_count_reg == KW'(NUM_KEYPOINTS - 1));
                kp_count_next          = kp_count_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            anchor_reg     <= '0;
            held_cx_reg    <= '0;
            held_cy_reg    <= '0;
            accepted_reg   <= 1'b0;
            kp_count_reg   <= '0;
            held_score_reg <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            anchor_reg     <= anchor_next;
            held_cx_reg    <= held_cx_next;
            held_cy_reg    <= held_cy_next;
            accepted_reg   <= accepted_next;
            kp_count_reg   <= kp_count_next;
            held_score_reg <= held_score_next;
        end
    end

endmodule

[hw/rtl/abpd_queue.sv]
// ----------------------------------------------------------------------------
// abpd_queue
// two-entry queue between the classifier and the coordinate back end
// ----------------------------------------------------------------------------
`include "anchor_box_proposal_decoder_defines.svh"

module abpd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  abpd_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output abpd_pkg::entry_t  q_entry
);
    import abpd_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    entry_t          slot_reg [Q_DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CW'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
            wptr_next = (wptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        if (pop)
            rptr_next = (rptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `ABPD_ASSERT_NOW(a_no_push_full, full, !push)
    `ABPD_ASSERT_NOW(a_no_pop_empty, !q_valid, !pop)
    `ABPD_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(Q_DEPTH))
    `ABPD_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + CW'(1))

endmodule

[hw/rtl/abpd_back.sv]
// ----------------------------------------------------------------------------
// abpd_back
// scales deltas by the stride, forms a box corner and size or a keypoint, saturates
// ----------------------------------------------------------------------------
module abpd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  abpd_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  abpd_pkg::entry_t      q_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_keypoint,
    output logic signed [23:0]    coord_a,
    output logic signed [23:0]    coord_b,
    output logic signed [16:0]    coord_c,
    output logic signed [16:0]    coord_d,
    output logic [15:0]           out_score,
    output logic                  last
);
    import abpd_pkg::*;

    localparam int SUM_W = 27;
    localparam int INT_W = SUM_W - 8;
    localparam int DIF_W = INT_W + 1;

    function automatic logic signed [INT_W-1:0] trunc_q8(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] b;
        // bias negatives so the drop of the fraction rounds toward zero
        b = v[SUM_W-1] ? v + SUM_W'(255) : v;
        return b[SUM_W-1:8];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [SUM_W-1:0] v);
        if (v > $signed(SUM_W'(24'h7fffff)))
            return 24'sh7fffff;
        else if (v < -$signed(SUM_W'(24'h800000)))
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [DIF_W-1:0] v);
        if (v > $signed(DIF_W'(17'h0ffff)))
            return 17'sh0ffff;
        else if (v < -$signed(DIF_W'(17'h10000)))
            return 17'sh10000;
        else
            return v[16:0];
    endfunction

    logic                     out_valid_reg, out_valid_next;
    logic                     is_kp_reg;
    logic signed [23:0]       ca_reg, cb_reg;
    logic signed [16:0]       cc_reg, cd_reg;
    logic [15:0]              score_reg;
    logic                     last_reg;

    logic signed [7:0]        s;
    logic signed [23:0]       pa, pb, pc, pd;
    logic signed [SUM_W-1:0]  cxq, cyq;
    logic signed [SUM_W-1:0]  xm, ym, xp, yp, xr, yr;
    logic signed [INT_W-1:0]  x0, y0, x1, y1;
    logic signed [DIF_W-1:0]  w, h;

    assign pop = q_valid && (!out_valid_reg || out_ready);

    assign s  = $signed({1'b0, cfg.stride});
    assign pa = 24'(q_entry.delta_a) * 24'(s);
    assign pb = 24'(q_entry.delta_b) * 24'(s);
    assign pc = 24'(q_entry.delta_c) * 24'(s);
    assign pd = 24'(q_entry.delta_d) * 24'(s);

    assign cxq = $signed({2'b00, q_entry.center_x, 8'h00});
    assign cyq = $signed({2'b00, q_entry.center_y, 8'h00});

    assign xm = cxq - {{(SUM_W-24){pa[23]}}, pa};
    assign ym = cyq - {{(SUM_W-24){pb[23]}}, pb};
    assign xp = cxq + {{(SUM_W-24){pa[23]}}, pa};
    assign yp = cyq + {{(SUM_W-24){pb[23]}}, pb};
    assign xr = cxq + {{(SUM_W-24){pc[23]}}, pc};
    assign yr = cyq + {{(SUM_W-24){pd[23]}}, pd};

    assign x0 = trunc_q8(xm);
    assign y0 = trunc_q8(ym);
    assign x1 = trunc_q8(xr);
    assign y1 = trunc_q8(yr);

    assign w = {x1[INT_W-1], x1} - {x0[INT_W-1], x0} + DIF_W'(1);
    assign h = {y1[INT_W-1], y1} - {y0[INT_W-1], y0} + DIF_W'(1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            is_kp_reg <= q_entry.is_keypoint;
            score_reg <= q_entry.score;
            last_reg  <= q_entry.last;
            if (q_entry.is_keypoint)
            begin
                ca_reg <= sat24(xp);
                cb_reg <= sat24(yp);
                cc_reg <= '0;
                cd_reg <= '0;
            end
            else
            begin
                ca_reg <= sat24({{(SUM_W-INT_W){x0[INT_W-1]}}, x0});
                cb_reg <= sat24({{(SUM_W-INT_W){y0[INT_W-1]}}, y0});
                cc_reg <= sat17(w);
                cd_reg <= sat17(h);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_keypoint = is_kp_reg;
    assign coord_a     = ca_reg;
    assign coord_b     = cb_reg;
    assign coord_c     = cc_reg;
    assign coord_d     = cd_reg;
    assign out_score   = score_reg;
    assign last        = last_reg;

endmodule
